// ----- sv/ibh_pkg.sv -----
// Package for the integer array bucket hash block.
// Holds word types, mix constants, widths and the back-end state type.
// No dependencies.
package ibh_pkg;

    localparam int HASH_W       = 32;
    localparam int BUCKET_W     = 31;
    localparam int ROT_AMT      = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [HASH_W-1:0] MIX_C1 = 32'h7ed55d16;
    localparam logic [HASH_W-1:0] MIX_C2 = 32'hc761c23c;
    localparam logic [HASH_W-1:0] MIX_C3 = 32'h165667b1;
    localparam logic [HASH_W-1:0] MIX_C4 = 32'hd3a2646c;
    localparam logic [HASH_W-1:0] MIX_C5 = 32'hfd7046c5;
    localparam logic [HASH_W-1:0] MIX_C6 = 32'hb55a4f09;

    typedef struct packed {
        logic [HASH_W-1:0] element;
        logic              last_element;
    } in_word_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                size_error;
    } out_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// ----- sv/ibh_queue.sv -----
// Small queue of finished array hashes between the front and back ends.
// Depends on ibh_pkg.
module ibh_queue
    import ibh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [HASH_W-1:0] push_data,
    input  logic              pop,
    output logic [HASH_W-1:0] pop_data,
    output queue_status_t     stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/ibh_front.sv -----
// Front end: four-stage integer mix pipeline and the rotate-xor accumulator.
// Pushes the finished hash of each array into the queue. Depends on ibh_pkg.
module ibh_front
    import ibh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              q_push,
    output logic [HASH_W-1:0] q_data,
    input  queue_status_t     q_stat
);

    logic [HASH_W-1:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic              vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic              lst1_reg, lst2_reg, lst3_reg, lst4_reg;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] st1_a, st1_b, st2_c, st3_d, mix_out;
    logic              advance;

    // The whole pipeline holds only when a last word cannot enter the queue.
    assign advance = !(vld4_reg && lst4_reg && q_stat.full);
    assign s_ready = advance;

    always_comb begin
        st1_a   = (s_data.element + MIX_C1) + (s_data.element << 12);
        st1_b   = (st1_a ^ MIX_C2) ^ (st1_a >> 19);
        st2_c   = (v1_reg + MIX_C3) + (v1_reg << 5);
        st3_d   = (v2_reg + MIX_C4) ^ (v2_reg << 9);
        mix_out = (v4_reg ^ MIX_C6) ^ (v4_reg >> 16);
        hash_next = {hash_reg[HASH_W-ROT_AMT-1:0], hash_reg[HASH_W-1:HASH_W-ROT_AMT]}
                    ^ mix_out;
    end

    assign q_push = advance && vld4_reg && lst4_reg;
    assign q_data = hash_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            hash_reg <= '0;
        end else if (advance) begin
            vld1_reg <= s_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            if (vld4_reg) begin
                hash_reg <= lst4_reg ? '0 : hash_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            v1_reg   <= st1_b;
            lst1_reg <= s_data.last_element;
            v2_reg   <= st2_c;
            lst2_reg <= lst1_reg;
            v3_reg   <= st3_d;
            lst3_reg <= lst2_reg;
            v4_reg   <= (v3_reg + MIX_C5) + (v3_reg << 3);
            lst4_reg <= lst3_reg;
        end
    end

endmodule

// ----- sv/ibh_back.sv -----
// Back end: bit-serial restoring modulo of each array hash and the output register.
// Depends on ibh_pkg.
module ibh_back
    import ibh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [BUCKET_W-1:0] bucket_count,
    output logic                q_pop,
    input  logic [HASH_W-1:0]   q_data,
    input  queue_status_t       q_stat,
    output logic                m_valid,
    input  logic                m_ready,
    output out_word_t           m_data
);

    localparam int CNT_W = $clog2(HASH_W + 1);

    back_state_t          state_reg, state_next;
    logic [BUCKET_W-1:0]  rem_reg;
    logic [HASH_W-1:0]    dvd_reg;
    logic [BUCKET_W-1:0]  div_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 err_reg;
    logic                 out_valid_reg;
    out_word_t            out_reg;
    logic [BUCKET_W:0]    trial;
    logic                 trial_ge;
    logic                 out_load;
    logic                 zero_count;

    assign zero_count = (bucket_count == '0);
    assign trial      = {rem_reg, dvd_reg[HASH_W-1]};
    assign trial_ge   = (trial >= {1'b0, div_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = zero_count ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop    = !q_stat.empty;
            BK_DIV:  q_pop    = 1'b0;
            BK_DONE: out_load = !out_valid_reg || m_ready;
            default: q_pop    = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rem_reg <= '0;
            dvd_reg <= q_data;
            div_reg <= bucket_count;
            cnt_reg <= CNT_W'(HASH_W);
            err_reg <= zero_count;
        end else if (state_reg == BK_DIV) begin
            rem_reg <= trial_ge ? BUCKET_W'(trial - {1'b0, div_reg}) : trial[BUCKET_W-1:0];
            dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (out_load) begin
            out_reg.bucket     <= rem_reg;
            out_reg.size_error <= err_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- sv/int_array_bucket_hash.sv -----
// Top level of the integer array bucket hash block.
// Connects front end, hash queue and modulo back end; depends on ibh_pkg.
//
//   port group   direction   word / content
//   s_*          in          in_word_t: element, last_element
//   m_*          out         out_word_t: bucket, size_error
//   cfg_*        in          bucket_count write, no read-back
//
// Elements are taken one per cycle unless a finished hash waits on a full
// queue; an array's hash is pushed into the queue as its last element leaves
// the mix pipeline. The modulo unit takes one result at a time and reduces
// it serially, so short arrays are paced by the divider once the queue fills.
// Reset is synchronous and active low and empties pipeline, queue and output.
// A stalled output only stalls the input when the queue is full.
module int_array_bucket_hash
    import ibh_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_word_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_word_t           m_data,
    input  logic                cfg_we,
    input  logic [BUCKET_W-1:0] cfg_wdata
);

    logic [BUCKET_W-1:0] bucket_count_reg;
    logic                q_push, q_pop;
    logic [HASH_W-1:0]   q_push_data, q_pop_data;
    queue_status_t       q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BUCKET_W'(1);
        end else if (cfg_we) begin
            bucket_count_reg <= cfg_wdata;
        end
    end

    ibh_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_push_data),
        .q_stat  (q_stat)
    );

    ibh_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    ibh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bucket_count (bucket_count_reg),
        .q_pop        (q_pop),
        .q_data       (q_pop_data),
        .q_stat       (q_stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// ----- sv/ibh_checker.sv -----
// Port-level checks for the integer array bucket hash block, bound to the top level.
// Depends on ibh_pkg.
module ibh_checker
    import ibh_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input in_word_t            s_data,
    input logic                m_valid,
    input logic                m_ready,
    input out_word_t           m_data,
    input logic                cfg_we,
    input logic [BUCKET_W-1:0] cfg_wdata
);

    logic [BUCKET_W-1:0] count_shadow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_shadow_reg <= BUCKET_W'(1);
        end else if (cfg_we) begin
            count_shadow_reg <= cfg_wdata;
        end
    end

    // An offered input word stays put until the block takes it.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // A word held back by the sink keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_err_bucket: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.size_error |-> m_data.bucket == '0 && count_shadow_reg == '0)
        else $error("size error word inconsistent");

    // Without an error the bucket lies inside the configured table.
    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.size_error |-> m_data.bucket < count_shadow_reg)
        else $error("bucket outside table");

endmodule

bind int_array_bucket_hash ibh_checker u_ibh_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
);
